>>> design/range_pixel_from_point_top_defines.svh
// assertion macros shared by the range pixel block
`ifndef RANGE_PIXEL_FROM_POINT_TOP_DEFINES_SVH
`define RANGE_PIXEL_FROM_POINT_TOP_DEFINES_SVH

// same-cycle implication on the block clock, off during reset
`define RPFP_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock, off during reset
`define RPFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rpfp_pkg.sv
// shared types and constants of the range pixel block
package rpfp_pkg;

    localparam int COORD_BITS      = 24;
    localparam int FOCAL_BITS      = 16;
    localparam int FOCAL_FRAC_BITS = 14;
    localparam int RANGE_BITS      = 24;
    localparam int GREY_BITS       = 8;
    localparam int SCALE_BITS      = 32;
    localparam int SCALE_FRAC_LIN  = 24;
    localparam int SCALE_FRAC_QUAD = 28;
    localparam int ROOT_PAD_BITS   = 8;
    localparam int SQRT_IN_BITS    = RANGE_BITS + ROOT_PAD_BITS;
    localparam int ROOT_BITS       = SQRT_IN_BITS / 2;
    localparam int DOT_BITS        = FOCAL_BITS + COORD_BITS + 2;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int GREY_MAX        = 255;

    localparam logic [FOCAL_BITS-1:0] FOCAL_Z_RESET    = 16'd16384;
    localparam logic [SCALE_BITS-1:0] GREY_SCALE_RESET = 32'd16777216;
    localparam logic [RANGE_BITS-1:0] RANGE_MAX        = '1;

    // register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_QUAD_MODE  = 3'd0,
        CFG_FOCAL_X    = 3'd1,
        CFG_FOCAL_Y    = 3'd2,
        CFG_FOCAL_Z    = 3'd3,
        CFG_GREY_SCALE = 3'd4
    } t_cfg_idx;

    // input beat
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic                         frame_start;
    } t_point_in;

    // output beat
    typedef struct packed {
        logic [RANGE_BITS-1:0] range_value;
        logic                  has_depth;
        logic                  behind_plane;
        logic [GREY_BITS-1:0]  grey_level;
        logic [RANGE_BITS-1:0] frame_max;
    } t_pixel_out;

endpackage

>>> design/range_pixel_from_point_top.sv
// top level: point to range-image pixel with running frame maximum
//
// channel  handshake                 payload      dir
// point    i_pt_valid / o_pt_ready   i_pt         in
// pixel    o_px_valid / i_px_ready   o_px         out
// config   i_cfg_we                  i_cfg_idx,   in
//                                    i_cfg_data
//
// one point in flight; a point with no depth or behind the plane goes from the
// dot product straight to the output, linear mode adds the multiply and
// square-root mode the root before it; the bit-serial dot product, the root
// and the shift-add multiply run one after the other.
// the next point is taken while a finished pixel still waits in the output
// register; the sequencer holds in its last step until that register frees.
// synchronous active-low reset restores the register defaults and clears
// the running maximum.
`include "range_pixel_from_point_top_defines.svh"

module range_pixel_from_point_top #(
    parameter int FOCAL_FRAC_BITS = rpfp_pkg::FOCAL_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pt_valid,
    output logic                                o_pt_ready,
    input  rpfp_pkg::t_point_in                 i_pt,
    output logic                                o_px_valid,
    input  logic                                i_px_ready,
    output rpfp_pkg::t_pixel_out                o_px,
    input  logic                                i_cfg_we,
    input  logic [rpfp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [rpfp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    import rpfp_pkg::*;

    localparam int PROD_W = SCALE_BITS + RANGE_BITS;
    localparam logic [PROD_W:0] FULL_LIN  = (PROD_W+1)'(GREY_MAX) << SCALE_FRAC_LIN;
    localparam logic [PROD_W:0] FULL_QUAD = (PROD_W+1)'(GREY_MAX) << SCALE_FRAC_QUAD;
    localparam logic [PROD_W:0] HALF_LIN  = (PROD_W+1)'(1) << (SCALE_FRAC_LIN - 1);
    localparam logic [PROD_W:0] HALF_QUAD = (PROD_W+1)'(1) << (SCALE_FRAC_QUAD - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOT,
        S_EVAL,
        S_SQRT,
        S_MUL,
        S_GREY,
        S_OUT
    } t_state;

    // configuration registers
    logic                  r_quad;
    logic [FOCAL_BITS-1:0] r_fx, r_fy, r_fz;
    logic [SCALE_BITS-1:0] r_scale;

    // sequencer and datapath registers
    t_state                r_state, n_state;
    logic                  r_px_valid, n_px_valid;
    t_pixel_out            r_px, n_px;
    logic [RANGE_BITS-1:0] r_max, n_max;
    logic [RANGE_BITS-1:0] r_range, n_range;
    logic                  r_depth, n_depth;
    logic                  r_behind, n_behind;
    logic [GREY_BITS-1:0]  r_grey, n_grey;

    // unit connections
    logic                  w_pt_acc;
    logic                  w_dot_done;
    logic [DOT_BITS-1:0]   w_dot, w_dot_sh;
    logic [RANGE_BITS-1:0] w_range_sat;
    logic                  w_sqrt_start, w_sqrt_done;
    logic [ROOT_BITS-1:0]  w_root;
    logic                  w_mul_start, w_mul_done;
    logic [RANGE_BITS-1:0] w_mul_b;
    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W:0]       w_full, w_half, w_prod_x, w_diff;
    logic [GREY_BITS-1:0]  w_grey;
    logic                  w_valid_pt;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad  <= 1'b0;
            r_fx    <= '0;
            r_fy    <= '0;
            r_fz    <= FOCAL_Z_RESET;
            r_scale <= GREY_SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_QUAD_MODE:  r_quad  <= i_cfg_data[0];
                CFG_FOCAL_X:    r_fx    <= i_cfg_data[FOCAL_BITS-1:0];
                CFG_FOCAL_Y:    r_fy    <= i_cfg_data[FOCAL_BITS-1:0];
                CFG_FOCAL_Z:    r_fz    <= i_cfg_data[FOCAL_BITS-1:0];
                CFG_GREY_SCALE: r_scale <= i_cfg_data[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_pt_ready = (r_state == S_IDLE);
    assign w_pt_acc   = i_pt_valid && o_pt_ready;
    assign w_valid_pt = r_depth && !r_behind;

    // dot product of the point with the focal vector
    rpfp_dot_serial #(
        .COORD_W (COORD_BITS),
        .FOCAL_W (FOCAL_BITS)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_pt_acc),
        .i_px    (i_pt.point_x),
        .i_py    (i_pt.point_y),
        .i_pz    (i_pt.point_z),
        .i_fx    (r_fx),
        .i_fy    (r_fy),
        .i_fz    (r_fz),
        .o_done  (w_dot_done),
        .o_dot   (w_dot)
    );

    // range: drop the focal fraction bits and saturate
    always_comb begin
        w_dot_sh    = w_dot >> FOCAL_FRAC_BITS;
        w_range_sat = (w_dot_sh[DOT_BITS-1:RANGE_BITS] != '0) ? RANGE_MAX
                                                               : w_dot_sh[RANGE_BITS-1:0];
    end

    // square root of range in q.4
    assign w_sqrt_start = (r_state == S_EVAL) && w_valid_pt && r_quad;

    rpfp_sqrt_serial #(
        .IN_W (SQRT_IN_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value ({r_range, {ROOT_PAD_BITS{1'b0}}}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // scale times range or root
    assign w_mul_start = ((r_state == S_EVAL) && w_valid_pt && !r_quad)
                      || ((r_state == S_SQRT) && w_sqrt_done);
    assign w_mul_b     = r_quad ? RANGE_BITS'(w_root) : r_range;

    rpfp_mul_serial #(
        .A_W (SCALE_BITS),
        .B_W (RANGE_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_scale),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // grey = round half up of 255 - product, zero once product passes 255
    always_comb begin
        w_full   = r_quad ? FULL_QUAD : FULL_LIN;
        w_half   = r_quad ? HALF_QUAD : HALF_LIN;
        w_prod_x = {1'b0, w_prod};
        w_diff   = w_full + w_half - w_prod_x;
        if (w_prod_x > w_full) begin
            w_grey = '0;
        end else if (r_quad) begin
            w_grey = w_diff[SCALE_FRAC_QUAD +: GREY_BITS];
        end else begin
            w_grey = w_diff[SCALE_FRAC_LIN +: GREY_BITS];
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_px_valid = r_px_valid && !i_px_ready;
        n_px       = r_px;
        n_max      = r_max;
        n_range    = r_range;
        n_depth    = r_depth;
        n_behind   = r_behind;
        n_grey     = r_grey;
        unique case (r_state)
            S_IDLE: begin
                if (w_pt_acc) begin
                    n_depth = (i_pt.point_x != '0) || (i_pt.point_y != '0)
                           || (i_pt.point_z != '0);
                    if (i_pt.frame_start) begin
                        n_max = '0;
                    end
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (w_dot_done) begin
                    n_behind = r_depth && w_dot[DOT_BITS-1];
                    n_range  = (r_depth && !w_dot[DOT_BITS-1]) ? w_range_sat : '0;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!w_valid_pt) begin
                    n_grey  = '0;
                    n_state = S_OUT;
                end else begin
                    if (r_range > r_max) begin
                        n_max = r_range;
                    end
                    n_state = r_quad ? S_SQRT : S_MUL;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_GREY;
                end
            end
            S_GREY: begin
                n_grey  = w_grey;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_px_valid || i_px_ready) begin
                    n_px.range_value  = r_range;
                    n_px.has_depth    = r_depth;
                    n_px.behind_plane = r_behind;
                    n_px.grey_level   = r_grey;
                    n_px.frame_max    = r_max;
                    n_px_valid        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_px_valid <= 1'b0;
            r_max      <= '0;
        end else begin
            r_state    <= n_state;
            r_px_valid <= n_px_valid;
            r_max      <= n_max;
        end
        r_px     <= n_px;
        r_range  <= n_range;
        r_depth  <= n_depth;
        r_behind <= n_behind;
        r_grey   <= n_grey;
    end

    assign o_px_valid = r_px_valid;
    assign o_px       = r_px;

    // checks
    `RPFP_ASSERT_HOLDS(a_invalid_zero, o_px_valid && (o_px.behind_plane || !o_px.has_depth), (o_px.range_value == '0) && (o_px.grey_level == '0), "invalid pixel carries range or grey")
    `RPFP_ASSERT_HOLDS(a_max_covers, o_px_valid, o_px.frame_max >= o_px.range_value, "frame maximum below pixel range")
    `RPFP_ASSERT_NEXT(a_one_in_flight, w_pt_acc, !o_pt_ready, "point taken while another is in flight")
    `RPFP_ASSERT_HOLDS(a_dot_in_step, w_dot_done, r_state == S_DOT, "dot product finished outside its step")

endmodule

>>> design/rpfp_dot_serial.sv
// bit-serial three-term dot product, coordinate bits msb first
module rpfp_dot_serial #(
    parameter int COORD_W = rpfp_pkg::COORD_BITS,
    parameter int FOCAL_W = rpfp_pkg::FOCAL_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [COORD_W-1:0]         i_px,
    input  logic [COORD_W-1:0]         i_py,
    input  logic [COORD_W-1:0]         i_pz,
    input  logic [FOCAL_W-1:0]         i_fx,
    input  logic [FOCAL_W-1:0]         i_fy,
    input  logic [FOCAL_W-1:0]         i_fz,
    output logic                       o_done,
    output logic [FOCAL_W+COORD_W+1:0] o_dot
);

    localparam int ACC_W  = FOCAL_W + COORD_W + 2;
    localparam int TERM_W = FOCAL_W + 2;
    localparam int CNT_W  = $clog2(COORD_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COORD_W-1:0] r_sx, n_sx;
    logic [COORD_W-1:0] r_sy, n_sy;
    logic [COORD_W-1:0] r_sz, n_sz;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [TERM_W-1:0]  w_ex, w_ey, w_ez, w_sum, w_term;

    // focal terms selected by the current coordinate bits
    always_comb begin
        w_ex   = r_sx[COORD_W-1] ? {{2{i_fx[FOCAL_W-1]}}, i_fx} : '0;
        w_ey   = r_sy[COORD_W-1] ? {{2{i_fy[FOCAL_W-1]}}, i_fy} : '0;
        w_ez   = r_sz[COORD_W-1] ? {{2{i_fz[FOCAL_W-1]}}, i_fz} : '0;
        w_sum  = w_ex + w_ey + w_ez;
        // the sign bit of a two's complement coordinate weighs negative
        w_term = (r_cnt == CNT_W'(COORD_W - 1)) ? (TERM_W'(0) - w_sum) : w_sum;
    end

    // horner step: acc = 2*acc + term
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_sz   = r_sz;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(COORD_W - 1);
            n_sx   = i_px;
            n_sy   = i_py;
            n_sz   = i_pz;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = {r_acc[ACC_W-2:0], 1'b0}
                  + {{(ACC_W-TERM_W){w_term[TERM_W-1]}}, w_term};
            n_sx  = {r_sx[COORD_W-2:0], 1'b0};
            n_sy  = {r_sy[COORD_W-2:0], 1'b0};
            n_sz  = {r_sz[COORD_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_sz  <= n_sz;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_dot  = r_acc;

endmodule

>>> design/rpfp_sqrt_serial.sv
// restoring integer square root, two radicand bits per cycle
module rpfp_sqrt_serial #(
    parameter int IN_W = rpfp_pkg::SQRT_IN_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [IN_W-1:0]     i_value,
    output logic                o_done,
    output logic [IN_W/2-1:0]   o_root
);

    localparam int ROOT_W = IN_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 1;
    localparam int WORK_W = ROOT_W + 3;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IN_W-1:0]   r_val, n_val;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [WORK_W-1:0] w_rem_sh, w_trial, w_diff;
    logic              w_ge;

    // trial subtraction of 4*root+1 from the shifted remainder
    always_comb begin
        w_rem_sh = {r_rem, r_val[IN_W-1 -: 2]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_diff   = w_rem_sh - w_trial;
        w_ge     = (w_rem_sh >= w_trial);
    end

    // sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ROOT_W - 1);
            n_val  = i_value;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            n_root = {r_root[ROOT_W-2:0], w_ge};
            n_val  = {r_val[IN_W-3:0], 2'b00};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> design/rpfp_mul_serial.sv
// shift-add unsigned multiplier, one multiplier bit per cycle lsb first
module rpfp_mul_serial #(
    parameter int A_W = rpfp_pkg::SCALE_BITS,
    parameter int B_W = rpfp_pkg::RANGE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int PROD_W = A_W + B_W;
    localparam int CNT_W  = $clog2(B_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [A_W-1:0]    r_a, n_a;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [A_W:0]      w_sum;

    // add the multiplicand into the upper half when the low bit is set
    always_comb begin
        w_sum = {1'b0, r_prod[PROD_W-1:B_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
    end

    // sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_prod = r_prod;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(B_W - 1);
            n_a    = i_a;
            n_prod = {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            n_prod = {w_sum, r_prod[B_W-1:1]};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_a    <= n_a;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
